// ===== hw/rtl/lgaiq_pkg.sv =====
// Shared types and constants for the leftmost-greater index query block.
// No dependencies; every other file in hw/rtl but lgaiq_ram imports this package.
package lgaiq_pkg;

  // Fixed field widths of the ports and of the command kind.
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned HEIGHT_IN_W = 32;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned KIND_W      = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Item mode codes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

  // Command kinds passed from the front to the back.
  typedef enum logic [KIND_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_RESULT = 2'd2
  } cmd_kind_e;

endpackage

// ===== hw/rtl/lgaiq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lgaiq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lgaiq_front.sv =====
// Front end: accepts items, range-checks and orders query indices, and
// turns each item into a command for the queue. Depends on lgaiq_pkg.
module lgaiq_front #(
  parameter int unsigned MAX_BUILDINGS = 1024,
  parameter int unsigned HEIGHT_BITS   = 32,
  localparam int unsigned AW   = $clog2(MAX_BUILDINGS),
  localparam int unsigned CW   = $clog2(MAX_BUILDINGS + 1),
  localparam int unsigned CmdW = lgaiq_pkg::KIND_W + lgaiq_pkg::STATUS_W + 2 * AW + CW
                                 + HEIGHT_BITS
) (
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [lgaiq_pkg::INDEX_W-1:0]      first_index_i,
  input  logic [lgaiq_pkg::INDEX_W-1:0]      second_index_i,
  input  logic [lgaiq_pkg::HEIGHT_IN_W-1:0]  height_value_i,
  input  logic [lgaiq_pkg::COUNT_W-1:0]      building_count_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output logic [CmdW-1:0]                    cmd_o
);

  import lgaiq_pkg::*;

  localparam int unsigned WW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [WW-1:0] MaxW = WW'(MAX_BUILDINGS);

  typedef struct packed {
    cmd_kind_e               kind;
    logic [STATUS_W-1:0]     status;
    logic [AW-1:0]           lo;
    logic [AW-1:0]           hi;
    logic [CW-1:0]           limit;
    logic [HEIGHT_BITS-1:0]  height;
  } cmd_t;

  cmd_t          cmd;
  logic [WW-1:0] count_w, eff_w, a_w, b_w, lo_w, hi_w;
  logic          accept, drop;

  assign count_w = WW'(building_count_i);
  assign eff_w   = (count_w > MaxW) ? MaxW : count_w;
  assign a_w     = WW'(first_index_i);
  assign b_w     = WW'(second_index_i);
  assign lo_w    = (a_w < b_w) ? a_w : b_w;
  assign hi_w    = (a_w < b_w) ? b_w : a_w;

  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_LOAD;
    cmd.lo     = AW'(first_index_i);
    cmd.height = HEIGHT_BITS'(height_value_i);
    if (mode_i == MODE_QUERY) begin
      cmd.limit = CW'(eff_w);
      cmd.lo    = AW'(lo_w);
      cmd.hi    = AW'(hi_w);
      if ((a_w >= eff_w) || (b_w >= eff_w)) begin
        cmd.kind   = CMD_RESULT;
        cmd.status = STATUS_BAD;
        cmd.hi     = '0;
      end else if (lo_w == hi_w) begin
        // Equal indices answer with the index itself, no heights needed.
        cmd.kind   = CMD_RESULT;
        cmd.status = STATUS_FOUND;
      end else begin
        cmd.kind = CMD_QUERY;
      end
    end
  end

  // Loads past the end of the store are taken and then dropped.
  assign drop       = (mode_i == MODE_LOAD) && (a_w >= MaxW);
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept && !drop;
  assign cmd_o      = cmd;

endmodule

// ===== hw/rtl/lgaiq_queue.sv =====
// Small command queue between the front end and the back end.
// Depends on lgaiq_pkg for its depth, which must be a power of two.
module lgaiq_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  import lgaiq_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

  logic [Width-1:0] slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthC);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/lgaiq_back.sv =====
// Back end: executes queued commands against the height RAM, scanning one
// height per cycle for queries, and holds the result register.
// Depends on lgaiq_pkg and lgaiq_ram.
module lgaiq_back #(
  parameter int unsigned MAX_BUILDINGS = 1024,
  parameter int unsigned HEIGHT_BITS   = 32,
  localparam int unsigned AW   = $clog2(MAX_BUILDINGS),
  localparam int unsigned CW   = $clog2(MAX_BUILDINGS + 1),
  localparam int unsigned CmdW = lgaiq_pkg::KIND_W + lgaiq_pkg::STATUS_W + 2 * AW + CW
                                 + HEIGHT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [CmdW-1:0]               cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lgaiq_pkg::INDEX_W-1:0] answer_index_o,
  output logic [lgaiq_pkg::STATUS_W-1:0] status_o
);

  import lgaiq_pkg::*;

  localparam int unsigned WW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef struct packed {
    cmd_kind_e               kind;
    logic [STATUS_W-1:0]     status;
    logic [AW-1:0]           lo;
    logic [AW-1:0]           hi;
    logic [CW-1:0]           limit;
    logic [HEIGHT_BITS-1:0]  height;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_HI,
    S_COMPARE,
    S_SCAN,
    S_EMIT
  } state_e;

  cmd_t                   head;
  state_e                 state_q, state_d;
  logic [AW-1:0]          hi_q, hi_d, cur_q, cur_d, res_idx_q, res_idx_d;
  logic [CW-1:0]          limit_q, limit_d;
  logic [HEIGHT_BITS-1:0] ref_q, ref_d;
  logic [STATUS_W-1:0]    res_st_q, res_st_d, status_q, status_d;
  logic [INDEX_W-1:0]     answer_q, answer_d;
  logic                   out_valid_q, out_valid_d;
  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [HEIGHT_BITS-1:0] ram_rdata;
  logic [WW-1:0]          nxt_w;
  logic                   out_free;

  assign head = cmd_t'(cmd_i);

  lgaiq_ram #(
    .Width (HEIGHT_BITS),
    .Depth (MAX_BUILDINGS)
  ) i_height_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head.lo),
    .wdata_i (head.height),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Index after the one whose height is on the RAM output this cycle.
  assign nxt_w = (state_q == S_SCAN) ? (WW'(cur_q) + WW'(1)) : (WW'(hi_q) + WW'(1));

  always_comb begin
    state_d     = state_q;
    hi_d        = hi_q;
    cur_d       = cur_q;
    limit_d     = limit_q;
    ref_d       = ref_q;
    res_idx_d   = res_idx_q;
    res_st_d    = res_st_q;
    answer_d    = answer_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = head.lo;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (head.kind)
            CMD_LOAD: begin
              ram_we = 1'b1;
            end
            CMD_QUERY: begin
              hi_d    = head.hi;
              limit_d = head.limit;
              state_d = S_READ_HI;
            end
            CMD_RESULT: begin
              res_idx_d = head.hi;
              res_st_d  = head.status;
              state_d   = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_READ_HI: begin
        // The RAM now shows the height at the lower index.
        ram_raddr = hi_q;
        ref_d     = ram_rdata;
        state_d   = S_COMPARE;
      end
      S_COMPARE: begin
        ram_raddr = nxt_w[AW-1:0];
        if (ref_q < ram_rdata) begin
          res_idx_d = hi_q;
          res_st_d  = STATUS_FOUND;
          state_d   = S_EMIT;
        end else if (nxt_w >= WW'(limit_q)) begin
          res_idx_d = '0;
          res_st_d  = STATUS_NONE;
          state_d   = S_EMIT;
        end else begin
          cur_d   = nxt_w[AW-1:0];
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // A read of the next index is issued every cycle, so one height is
        // checked per cycle.
        ram_raddr = nxt_w[AW-1:0];
        if (ram_rdata > ref_q) begin
          res_idx_d = cur_q;
          res_st_d  = STATUS_FOUND;
          state_d   = S_EMIT;
        end else if (nxt_w >= WW'(limit_q)) begin
          res_idx_d = '0;
          res_st_d  = STATUS_NONE;
          state_d   = S_EMIT;
        end else begin
          cur_d = nxt_w[AW-1:0];
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          answer_d    = (res_st_q == STATUS_FOUND) ? INDEX_W'(res_idx_q) : '0;
          status_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hi_q        <= '0;
      cur_q       <= '0;
      limit_q     <= '0;
      ref_q       <= '0;
      res_idx_q   <= '0;
      res_st_q    <= STATUS_NONE;
      answer_q    <= '0;
      status_q    <= STATUS_NONE;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hi_q        <= hi_d;
      cur_q       <= cur_d;
      limit_q     <= limit_d;
      ref_q       <= ref_d;
      res_idx_q   <= res_idx_d;
      res_st_q    <= res_st_d;
      answer_q    <= answer_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign answer_index_o = answer_q;
  assign status_o       = status_q;

endmodule

// ===== hw/rtl/leftmost_greater_after_index_query_core.sv =====
// Top level of the leftmost-greater index query block.
// Depends on lgaiq_pkg, lgaiq_front, lgaiq_queue, lgaiq_back and lgaiq_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: mode_i selects a
//   height load (first_index_i is the address) or a query on first_index_i and
//   second_index_i. Loads give no result; each query gives one result on the
//   output channel (out_valid_o/out_ready_i): answer_index_o and status_o.
//   The register building_count is written with cfg_we_i and building_count_i;
//   the user writes it only while the block is idle; nothing here enforces that.
// Timing:
//   The front end takes an item in the cycle it is offered while the two-entry
//   command queue has room. The back end writes a load to the height RAM in the
//   cycle it pops it. A query with a range error or equal indices goes straight
//   to the emit state; other queries read the heights at the lower and higher
//   index, then scan later heights up to the building count for a greater one.
//   With one RAM read port, one stored height is read and compared per cycle.
// Reset:
//   Reset empties the queue and the result register and sets building_count to
//   1024. The height RAM is not cleared; a query must only touch loaded entries.
// Back-pressure:
//   A result waits in the output register while out_ready_i is low; the back end
//   then holds its next result, and once the queue fills in_ready_o drops.
module leftmost_greater_after_index_query_core #(
  parameter int unsigned MAX_BUILDINGS = 1024,
  parameter int unsigned HEIGHT_BITS   = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lgaiq_pkg::COUNT_W-1:0]      building_count_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [lgaiq_pkg::INDEX_W-1:0]      first_index_i,
  input  logic [lgaiq_pkg::INDEX_W-1:0]      second_index_i,
  input  logic [lgaiq_pkg::HEIGHT_IN_W-1:0]  height_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lgaiq_pkg::INDEX_W-1:0]      answer_index_o,
  output logic [lgaiq_pkg::STATUS_W-1:0]     status_o
);

  import lgaiq_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_BUILDINGS);
  localparam int unsigned CW   = $clog2(MAX_BUILDINGS + 1);
  localparam int unsigned CmdW = KIND_W + STATUS_W + 2 * AW + CW + HEIGHT_BITS;

  logic [COUNT_W-1:0] building_count_q;
  logic               q_full, q_push, q_valid, q_pop;
  logic [CmdW-1:0]    cmd_in, cmd_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      building_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      building_count_q <= building_count_i;
    end
  end

  lgaiq_front #(
    .MAX_BUILDINGS (MAX_BUILDINGS),
    .HEIGHT_BITS   (HEIGHT_BITS)
  ) i_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .first_index_i    (first_index_i),
    .second_index_i   (second_index_i),
    .height_value_i   (height_value_i),
    .building_count_i (building_count_q),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .cmd_o            (cmd_in)
  );

  lgaiq_queue #(
    .Width (CmdW)
  ) i_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cmd_head)
  );

  lgaiq_back #(
    .MAX_BUILDINGS (MAX_BUILDINGS),
    .HEIGHT_BITS   (HEIGHT_BITS)
  ) i_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .cmd_i          (cmd_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .answer_index_o (answer_index_o),
    .status_o       (status_o)
  );

endmodule

// ===== hw/rtl/lgaiq_checker.sv =====
// Port-level checks for the leftmost-greater index query block, bound to
// the top level below. Depends on lgaiq_pkg.
module lgaiq_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [lgaiq_pkg::INDEX_W-1:0]  answer_index_o,
  input logic [lgaiq_pkg::STATUS_W-1:0] status_o
);

  import lgaiq_pkg::*;

  // The result register is empty once reset has been seen at a clock edge.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(answer_index_o)
                                    && $stable(status_o))
    else $error("stalled result changed");

  // Only the three defined status codes appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_FOUND) || (status_o == STATUS_NONE)
                    || (status_o == STATUS_BAD))
    else $error("undefined status code");

  // Without a match the answer index reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_FOUND) |-> answer_index_o == '0)
    else $error("nonzero answer without a match");

endmodule

bind leftmost_greater_after_index_query_core lgaiq_port_checker i_lgaiq_port_checker (.*);

// ===== test/lgaiq_checker.sv =====
// Checker for the leftmost-greater index query block: it mirrors the height store and
// the building count, predicts each query answer and compares it with the result seen.
// Depends on lgaiq_pkg only.
module lgaiq_checker
  import lgaiq_pkg::*;
#(
  parameter int unsigned MAX_BUILDINGS = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COUNT_W-1:0]     building_count_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   mode_i,
  input  logic [INDEX_W-1:0]     first_index_i,
  input  logic [INDEX_W-1:0]     second_index_i,
  input  logic [HEIGHT_IN_W-1:0] height_value_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [INDEX_W-1:0]     answer_index_i,
  input  logic [STATUS_W-1:0]    status_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [INDEX_W-1:0]  answer_index;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic [HEIGHT_IN_W-1:0] height_mirror [MAX_BUILDINGS];
  logic [COUNT_W-1:0]     count_mirror = COUNT_RESET;
  answer_t                awaited_answers [$];

  function automatic answer_t answer_for_query(input int a, input int b);
    answer_t                res;
    int                     lim;
    int                     lo;
    int                     hi;
    logic [HEIGHT_IN_W-1:0] ref_h;
    bit                     hit;
    res.answer_index = '0;
    res.status       = STATUS_NONE;
    // Counts above the store depth saturate.
    lim = (count_mirror > MAX_BUILDINGS) ? MAX_BUILDINGS : int'(count_mirror);
    if (a >= lim || b >= lim) begin
      res.status = STATUS_BAD;
      return res;
    end
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi || height_mirror[lo] < height_mirror[hi]) begin
      res.answer_index = hi[INDEX_W-1:0];
      res.status       = STATUS_FOUND;
    end else begin
      ref_h = height_mirror[lo];
      hit   = 1'b0;
      for (int j = hi + 1; j < lim; j++) begin
        if (!hit && height_mirror[j] > ref_h) begin
          hit              = 1'b1;
          res.answer_index = j[INDEX_W-1:0];
          res.status       = STATUS_FOUND;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      count_mirror = COUNT_RESET;
      awaited_answers.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.answer_index = answer_index_i;
        got.status       = status_i;
        if (awaited_answers.size() == 0) begin
          $error("result with no query waiting: answer_index %0d, status %0d",
                 got.answer_index, got.status);
          fail_count_o++;
        end else begin
          want = awaited_answers.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count_o++;
          end
          if (got.answer_index !== want.answer_index) begin
            $error("answer_index: expected %0d, actual %0d",
                   want.answer_index, got.answer_index);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) count_mirror = building_count_i;
      if (in_valid_i && in_ready_i) begin
        if (mode_i == MODE_LOAD) height_mirror[first_index_i] = height_value_i;
        else awaited_answers.push_back(answer_for_query(first_index_i, second_index_i));
      end
    end
    pending_o = awaited_answers.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the testbench for leftmost_greater_after_index_query_core: clock, reset,
// directed and random items, output stalls and the verdict.
// Depends on lgaiq_pkg, the block's RTL and lgaiq_checker.
module testbench;
  import lgaiq_pkg::*;

  localparam int unsigned BUILDINGS = 1024;
  localparam int unsigned SLOTS_PER_PHASE = 26;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_pattern_e;

  logic                   clk_i            = 1'b0;
  logic                   rst_ni           = 1'b0;
  logic                   cfg_we_i         = 1'b0;
  logic [COUNT_W-1:0]     building_count_i = COUNT_RESET;
  logic                   in_valid_i       = 1'b0;
  logic                   in_ready_o;
  logic                   mode_i           = MODE_LOAD;
  logic [INDEX_W-1:0]     first_index_i    = '0;
  logic [INDEX_W-1:0]     second_index_i   = '0;
  logic [HEIGHT_IN_W-1:0] height_value_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i      = 1'b0;
  logic [INDEX_W-1:0]     answer_index_o;
  logic [STATUS_W-1:0]    status_o;
  int                     fail_count;
  int                     pending_answers;

  // What the stimulus has loaded so far, so that no query reads an unloaded entry.
  logic [HEIGHT_IN_W-1:0] sent_height  [BUILDINGS];
  bit                     sent_written [BUILDINGS];
  int                     live_count = BUILDINGS;
  int                     burst_left = 0;

  int phase_counts [12] = '{2, 3, 16, 40, 1024, 1500, 64, 2047, 7, 0, 100, 1};

  leftmost_greater_after_index_query_core #(
    .MAX_BUILDINGS(BUILDINGS),
    .HEIGHT_BITS  (32)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .building_count_i(building_count_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .first_index_i   (first_index_i),
    .second_index_i  (second_index_i),
    .height_value_i  (height_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .answer_index_o  (answer_index_o),
    .status_o        (status_o)
  );

  lgaiq_checker #(
    .MAX_BUILDINGS(BUILDINGS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .building_count_i(building_count_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .mode_i          (mode_i),
    .first_index_i   (first_index_i),
    .second_index_i  (second_index_i),
    .height_value_i  (height_value_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .answer_index_i  (answer_index_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_answers)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("leftmost_greater_after_index_query_core: mismatch");
    $finish;
  end

  // The receiver picks a new stall pattern at random each time the current one runs out.
  ready_pattern_e ready_mode = READY_ALWAYS;
  int             ready_left = 0;
  int             ready_tick = 0;

  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = ready_pattern_e'($urandom_range(0, 3));
      ready_left = $urandom_range(20, 400);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:   out_ready_i <= 1'b1;
      READY_COIN:     out_ready_i <= $urandom_range(0, 1);
      READY_SPARSE:   out_ready_i <= ($urandom_range(0, 9) == 0);
      default:        out_ready_i <= ((ready_tick % 5) < 2);
    endcase
  end

  // Offers one item and returns at the edge where it is accepted.
  task automatic send_item(input logic mode, input logic [INDEX_W-1:0] a,
                           input logic [INDEX_W-1:0] b, input logic [HEIGHT_IN_W-1:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    first_index_i  <= a;
    second_index_i <= b;
    height_value_i <= h;
    if (mode == MODE_LOAD) begin
      sent_height[a]  = h;
      sent_written[a] = 1'b1;
    end
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Writes the building count once every query answer is back and loads have drained.
  task automatic write_count(input int value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i         <= 1'b1;
    building_count_i <= value[COUNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    live_count = (value > BUILDINGS) ? BUILDINGS : value;
  endtask

  function automatic logic [HEIGHT_IN_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 7);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // First entry the query would read that has not been loaded, or -1 if none.
  function automatic int unloaded_read(input int a, input int b);
    int lo;
    int hi;
    int need;
    bit done;
    if (a >= live_count || b >= live_count) return -1;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi) return -1;
    if (!sent_written[lo]) return lo;
    if (!sent_written[hi]) return hi;
    if (sent_height[lo] < sent_height[hi]) return -1;
    need = -1;
    done = 1'b0;
    for (int j = hi + 1; j < live_count; j++) begin
      if (!done) begin
        if (!sent_written[j]) begin
          need = j;
          done = 1'b1;
        end else if (sent_height[j] > sent_height[lo]) begin
          done = 1'b1;
        end
      end
    end
    return need;
  endfunction

  initial begin
    int a;
    int b;
    int r;
    int need;
    int fills;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset count of 1024.
    send_item(MODE_LOAD, 10'd0, $urandom, 32'd5);
    send_item(MODE_LOAD, 10'd1, $urandom, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 10'd2, $urandom, 32'd0);
    send_item(MODE_LOAD, 10'd3, $urandom, 32'd5);
    send_item(MODE_LOAD, 10'd4, $urandom, 32'd6);
    send_item(MODE_LOAD, 10'd1022, $urandom, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 10'd1023, $urandom, 32'h8000_0000);
    send_item(MODE_QUERY, 10'd0, 10'd0, $urandom);
    send_item(MODE_QUERY, 10'd3, 10'd0, $urandom);
    send_item(MODE_QUERY, 10'd0, 10'd2, $urandom);
    send_item(MODE_QUERY, 10'd2, 10'd4, $urandom);
    send_item(MODE_QUERY, 10'd0, 10'd1, $urandom);
    send_item(MODE_QUERY, 10'd1022, 10'd1023, $urandom);
    send_item(MODE_QUERY, 10'd1023, 10'd1023, $urandom);
    // A count of zero makes every index out of range.
    write_count(0);
    send_item(MODE_QUERY, 10'd0, 10'd0, $urandom);
    write_count(5);
    send_item(MODE_QUERY, 10'd5, 10'd0, $urandom);
    send_item(MODE_QUERY, 10'd0, 10'd5, $urandom);
    send_item(MODE_QUERY, 10'd2, 10'd1, $urandom);
    send_item(MODE_QUERY, 10'd4, 10'd4, $urandom);
    send_item(MODE_QUERY, 10'd1023, 10'd0, $urandom);
    write_count(1);
    send_item(MODE_QUERY, 10'd0, 10'd0, $urandom);
    send_item(MODE_QUERY, 10'd0, 10'd1, $urandom);
    // Counts above the store depth saturate.
    write_count(2047);
    send_item(MODE_QUERY, 10'd1022, 10'd1023, $urandom);
    send_item(MODE_QUERY, 10'd1023, 10'd1022, $urandom);

    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      for (int slot = 0; slot < SLOTS_PER_PHASE; slot++) begin
        if ($urandom_range(0, 9) < 3) begin
          if (live_count > 0 && $urandom_range(0, 6) != 0) a = $urandom_range(0, live_count - 1);
          else a = $urandom_range(0, BUILDINGS - 1);
          send_item(MODE_LOAD, a, $urandom, pick_height());
        end else begin
          r = $urandom_range(0, 9);
          if (live_count == 0) begin
            a = $urandom_range(0, BUILDINGS - 1);
            b = $urandom_range(0, BUILDINGS - 1);
          end else if (r == 0 && live_count < BUILDINGS) begin
            a = $urandom_range(live_count, BUILDINGS - 1);
            b = $urandom_range(0, BUILDINGS - 1);
            if ($urandom_range(0, 1)) begin
              need = a;
              a    = b;
              b    = need;
            end
          end else begin
            a = $urandom_range(0, live_count - 1);
            b = (r == 1) ? a : $urandom_range(0, live_count - 1);
          end
          // Load whatever the query would read first; give up if the scan runs long.
          fills = 0;
          need  = unloaded_read(a, b);
          while (need >= 0 && fills < 16) begin
            send_item(MODE_LOAD, need, $urandom, pick_height());
            fills++;
            need = unloaded_read(a, b);
          end
          if (need < 0) send_item(MODE_QUERY, a, b, $urandom);
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_answers == 0) begin
      $display("leftmost_greater_after_index_query_core: match");
    end else begin
      $display("leftmost_greater_after_index_query_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== leftmost_greater_after_index_query_core.f =====
hw/rtl/lgaiq_pkg.sv
hw/rtl/lgaiq_ram.sv
hw/rtl/lgaiq_front.sv
hw/rtl/lgaiq_queue.sv
hw/rtl/lgaiq_back.sv
hw/rtl/leftmost_greater_after_index_query_core.sv
hw/rtl/lgaiq_checker.sv
test/lgaiq_checker.sv
test/testbench.sv
